FILE: rtl/bad_pkg.sv
// shared types and constants for the block average decimator
package bad_pkg;

    // configuration port
    localparam int FACTOR_W   = 9;
    localparam int FACTOR_MAX = (1 << FACTOR_W) - 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FACTOR_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECIM_FACTOR = 1'b0,
        CFG_ENERGY_MODE  = 1'b1
    } cfg_idx_t;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_WAIT
    } bad_state_t;

    // divide and root unit
    typedef enum logic [2:0] {
        DR_IDLE,
        DR_DIV,
        DR_POST,
        DR_ROOT,
        DR_DONE
    } bad_dr_state_t;

endpackage

FILE: rtl/bad_divroot.sv
// bit-serial divide by block length followed by optional bit-serial square root
module bad_divroot #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 41,
    parameter int DIV_W       = 9
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [ACC_W-1:0]       acc_in,
    input  logic                   rms,
    input  logic [DIV_W-1:0]       divisor,
    output logic                   res_valid,
    input  logic                   res_take,
    output logic [SAMPLE_BITS:0]   result
);
    import bad_pkg::*;

    localparam int OUT_W  = SAMPLE_BITS + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int RW     = SAMPLE_BITS + 2;
    localparam int STEP_W = $clog2(ACC_W + 1);

    bad_dr_state_t state_reg, state_next;

    logic [ACC_W-1:0]       quo_reg, quo_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic                   neg_reg, neg_next;
    logic                   rms_reg, rms_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SQ_W-1:0]        xsh_reg, xsh_next;
    logic [RW-1:0]          srem_reg, srem_next;
    logic [SAMPLE_BITS-1:0] root_reg, root_next;
    logic [OUT_W-1:0]       res_reg, res_next;

    logic [DIV_W:0]         cand;
    logic [DIV_W:0]         diff;
    logic [RW+1:0]          scand;
    logic [RW+1:0]          strial;
    logic [OUT_W-1:0]       qlow;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        rms_reg  <= rms_next;
        step_reg <= step_next;
        xsh_reg  <= xsh_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        rms_next   = rms_reg;
        step_next  = step_reg;
        xsh_next   = xsh_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        res_next   = res_reg;
        res_valid  = 1'b0;

        cand   = {rem_reg, quo_reg[ACC_W-1]};
        diff   = cand - {1'b0, div_reg};
        scand  = {srem_reg, xsh_reg[SQ_W-1 -: 2]};
        strial = (RW+2)'({root_reg, 2'b01});
        qlow   = quo_reg[OUT_W-1:0];

        case (state_reg)
            DR_IDLE: begin
                if (start) begin
                    neg_next   = acc_in[ACC_W-1];
                    quo_next   = acc_in[ACC_W-1] ? (~acc_in + ACC_W'(1)) : acc_in;
                    rem_next   = '0;
                    div_next   = divisor;
                    rms_next   = rms;
                    step_next  = '0;
                    state_next = DR_DIV;
                end
            end
            DR_DIV: begin
                // restoring division, one quotient bit per cycle
                if (cand >= {1'b0, div_reg}) begin
                    rem_next = diff[DIV_W-1:0];
                    quo_next = {quo_reg[ACC_W-2:0], 1'b1};
                end else begin
                    rem_next = cand[DIV_W-1:0];
                    quo_next = {quo_reg[ACC_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ACC_W - 1)) begin
                    state_next = DR_POST;
                end
            end
            DR_POST: begin
                if (rms_reg) begin
                    xsh_next   = quo_reg[SQ_W-1:0];
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = DR_ROOT;
                end else begin
                    res_next   = neg_reg ? (~qlow + OUT_W'(1)) : qlow;
                    state_next = DR_DONE;
                end
            end
            DR_ROOT: begin
                // digit-by-digit root, one result bit per cycle
                if (scand >= strial) begin
                    srem_next = RW'(scand - strial);
                    root_next = {root_reg[SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    srem_next = RW'(scand);
                    root_next = {root_reg[SAMPLE_BITS-2:0], 1'b0};
                end
                xsh_next  = {xsh_reg[SQ_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SAMPLE_BITS - 1)) begin
                    res_next   = {1'b0, root_next};
                    state_next = DR_DONE;
                end
            end
            DR_DONE: begin
                res_valid = 1'b1;
                if (res_take) begin
                    state_next = DR_IDLE;
                end
            end
            default: begin
                state_next = DR_IDLE;
            end
        endcase
    end

    assign result = res_reg;

endmodule

FILE: rtl/block_average_decimator_core.sv
// top level of the block average decimator: block mean or rms over sample blocks
// usage
//   samples enter on s_valid/s_ready/s_sample, results leave on m_valid/m_ready/
//   m_value. every decim_factor accepted samples give one result: the block mean
//   truncated toward zero (energy_mode 0) or the floor of the block rms
//   (energy_mode 1). decim_factor 0 passes each sample through; factors above
//   MAX_FACTOR act as MAX_FACTOR. a partial block is never emitted.
//   configuration (cfg_we, cfg_index, cfg_data) is taken in the same cycle;
//   any write starts a fresh block. write only when idle.
// sequence
//   a sample inside a block goes through ST_CHECK in mean mode and through the
//   shift-and-add squarer (one multiplier bit per cycle) and ST_CHECK in rms mode
//   a closing sample's total goes from ST_CHECK to the serial divider (one
//   quotient bit per cycle), then DR_POST and, in rms mode, the serial root
//   before DR_DONE; ST_WAIT puts the result in the output register once that is
//   free; samples are taken only in ST_IDLE
//   pass-through results go straight into the output register at the transfer
// reset and stall
//   aresetn clears the block state and sets factor 1, mean mode. a stalled receiver
//   holds the result; samples are still taken until the next result needs it
module block_average_decimator_core #(
    parameter int MAX_FACTOR  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bad_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS:0]        m_value
);
    import bad_pkg::*;

    // largest block length reachable from the register
    localparam int CAP   = (MAX_FACTOR < FACTOR_MAX) ? MAX_FACTOR : FACTOR_MAX;
    localparam int EF_W  = $clog2(CAP + 1);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    // sum of squares of CAP samples stays below 2^(ACC_W-1)
    localparam int ACC_W = SQ_W + EF_W;
    localparam int BC_W  = $clog2(SAMPLE_BITS);
    localparam int OUT_W = SAMPLE_BITS + 1;

    bad_state_t state_reg, state_next;

    logic [FACTOR_W-1:0]    factor_reg, factor_next;
    logic                   mode_reg, mode_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [EF_W-1:0]        count_reg, count_next;
    logic [SQ_W-1:0]        mcand_reg, mcand_next;
    logic [SAMPLE_BITS-1:0] mplier_reg, mplier_next;
    logic [BC_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_value_reg, m_value_next;

    logic [EF_W-1:0]        eff_factor;
    logic                   pass_mode;
    logic                   out_free;
    logic                   s_xfer;
    logic [SAMPLE_BITS-1:0] s_mag;
    logic [ACC_W-1:0]       s_ext;

    logic                   div_start;
    logic                   res_valid;
    logic                   res_take;
    logic [OUT_W-1:0]       res_value;

    // saturate the register to the supported block length
    assign eff_factor = (factor_reg > FACTOR_W'(CAP)) ? EF_W'(CAP) : EF_W'(factor_reg);
    assign pass_mode  = (eff_factor == '0);
    assign out_free   = !m_valid_reg || m_ready;

    // pass-through needs the output register, block samples do not
    assign s_ready = (state_reg == ST_IDLE) && (!pass_mode || out_free);
    assign s_xfer  = s_valid && s_ready;

    assign s_mag = s_sample[SAMPLE_BITS-1] ? (~s_sample + SAMPLE_BITS'(1)) : s_sample;
    assign s_ext = {{(ACC_W-SAMPLE_BITS){s_sample[SAMPLE_BITS-1]}}, s_sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            factor_reg  <= FACTOR_W'(1);
            mode_reg    <= 1'b0;
            acc_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            factor_reg  <= factor_next;
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        bit_cnt_reg <= bit_cnt_next;
        m_value_reg <= m_value_next;
    end

    always_comb begin
        state_next   = state_reg;
        factor_next  = factor_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        count_next   = count_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        bit_cnt_next = bit_cnt_reg;
        m_value_next = m_value_reg;
        m_valid_next = m_valid_reg && !m_ready;
        div_start    = 1'b0;
        res_take     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (pass_mode) begin
                        // sample goes straight to the output register
                        m_value_next = {s_sample[SAMPLE_BITS-1], s_sample};
                        m_valid_next = 1'b1;
                    end else begin
                        count_next = count_reg + EF_W'(1);
                        if (mode_reg) begin
                            mcand_next   = SQ_W'(s_mag);
                            mplier_next  = s_mag;
                            bit_cnt_next = '0;
                            state_next   = ST_SQUARE;
                        end else begin
                            acc_next   = acc_reg + s_ext;
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_SQUARE: begin
                // shift-and-add square straight into the accumulator
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + ACC_W'(mcand_reg);
                end
                mcand_next   = {mcand_reg[SQ_W-2:0], 1'b0};
                mplier_next  = {1'b0, mplier_reg[SAMPLE_BITS-1:1]};
                bit_cnt_next = bit_cnt_reg + BC_W'(1);
                if (bit_cnt_reg == BC_W'(SAMPLE_BITS - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // block complete: hand the total to the divider, start over; else back to idle
                if (count_reg == eff_factor) begin
                    div_start  = 1'b1;
                    acc_next   = '0;
                    count_next = '0;
                    state_next = ST_WAIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (res_valid && out_free) begin
                    res_take     = 1'b1;
                    m_value_next = res_value;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // any register write starts a new block
        if (cfg_we) begin
            case (cfg_index)
                CFG_DECIM_FACTOR: factor_next = cfg_data;
                CFG_ENERGY_MODE:  mode_next   = cfg_data[0];
                default: ;
            endcase
            acc_next   = '0;
            count_next = '0;
        end
    end

    bad_divroot #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W),
        .DIV_W       (EF_W)
    ) u_divroot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .acc_in    (acc_reg),
        .rms       (mode_reg),
        .divisor   (eff_factor),
        .res_valid (res_valid),
        .res_take  (res_take),
        .result    (res_value)
    );

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

endmodule

FILE: test/tb_block_average_decimator_core.sv
// testbench for block_average_decimator_core: directed table plus randomized block phases
`timescale 1ns / 100ps

module tb_block_average_decimator_core;
    import bad_pkg::*;

    localparam int MAX_FACTOR  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int RANDOM_ITEMS = 1900;
    // rms worst case: squarer, serial divider and serial root, with margin
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD     = 400;
    localparam int LONG_HOLD_AT  = 60;
    localparam longint CYCLE_LIMIT = 1_500_000;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        cfg_idx_t  idx;
        int        value;
        int        smp;
        bit        typed;
        int        want;
    } stim_row_t;

    localparam int N_DIRECTED = 25;

    // directed table: typed results only where they are obvious
    stim_row_t directed_rows [0:N_DIRECTED-1] = '{
        // after reset: factor 1, mean mode, each sample is its own block
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,  32767, 1'b1,  32767},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0, -32768, 1'b1, -32768},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,      0, 1'b1,      0},
        // pass-through
        '{ROW_CFG,    CFG_DECIM_FACTOR,   0,      0, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,     -1, 1'b1,     -1},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,  12345, 1'b1,  12345},
        // mean of two, truncation toward zero and full scale
        '{ROW_CFG,    CFG_DECIM_FACTOR,   2,      0, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,     -1, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,     -2, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,  32767, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,  32767, 1'b1,  32767},
        // rms of two: most negative input gives the largest output
        '{ROW_CFG,    CFG_ENERGY_MODE,    1,      0, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0, -32768, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0, -32768, 1'b1,  32768},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,      3, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,      4, 1'b0,      0},
        // partial block thrown away by a register write
        '{ROW_CFG,    CFG_DECIM_FACTOR,   3,      0, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,   1000, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,   1000, 1'b0,      0},
        '{ROW_CFG,    CFG_ENERGY_MODE,    0,      0, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,      7, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,      7, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,    -20, 1'b0,      0},
        // factor above the maximum saturates, left as a partial block
        '{ROW_CFG,    CFG_DECIM_FACTOR, 511,      0, 1'b0,      0},
        '{ROW_SAMPLE, CFG_DECIM_FACTOR,   0,      5, 1'b0,      0}
    };

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS:0]   m_value;

    block_average_decimator_core #(
        .MAX_FACTOR (MAX_FACTOR),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value)
    );

    // predictor state: registers and the running block
    logic [CFG_DATA_W-1:0] factor_reg;
    logic                  mode_reg;
    longint                blk_sum;
    int                    blk_fill;

    // block values still owed by the block, oldest first
    logic signed [SAMPLE_BITS:0] owed_values [$];

    int     samples_sent;
    int     results_checked;
    int     mismatch_count;
    int     phase_count;
    int     rms_blocks;
    int     mean_blocks;
    int     pass_values;
    bit     send_idle;
    bit     recv_idle;
    longint cycle_count;
    // samples still to be offered in the running phase and its block length
    int     phase_left;
    int     phase_eff;
    bit     long_hold_done;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // runaway guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d values still owed", cycle_count,
                     owed_values.size());
            $display("FAIL block_average_decimator_core");
            $finish;
        end
    end

    // one sample into the running block; returns 1 when a value comes out
    function automatic bit decimate_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                           output logic signed [SAMPLE_BITS:0] value);
        int     f;
        longint quot;
        longint root;
        longint trial;
        f = (factor_reg > MAX_FACTOR) ? MAX_FACTOR : int'(factor_reg);
        value = '0;
        if (f == 0) begin
            value = (SAMPLE_BITS + 1)'(smp);
            pass_values++;
            return 1'b1;
        end
        if (mode_reg)
            blk_sum += longint'(smp) * longint'(smp);
        else
            blk_sum += longint'(smp);
        blk_fill++;
        if (blk_fill < f)
            return 1'b0;
        quot = blk_sum / f;
        if (mode_reg) begin
            // floor square root, one result bit at a time from the top
            root = 0;
            for (int b = SAMPLE_BITS; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= quot)
                    root = trial;
            end
            value = root[SAMPLE_BITS:0];
            rms_blocks++;
        end else begin
            value = quot[SAMPLE_BITS:0];
            mean_blocks++;
        end
        blk_sum  = 0;
        blk_fill = 0;
        return 1'b1;
    endfunction

    // called at a falling edge while idle; any write starts a fresh block
    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_DECIM_FACTOR)
            factor_reg = CFG_DATA_W'(value);
        else
            mode_reg = value[0];
        blk_sum  = 0;
        blk_fill = 0;
    endtask

    // stop offering, let every owed value arrive, then let the block go quiet
    task automatic wait_drained();
        s_valid = 1'b0;
        while (owed_values.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // offer one sample and hold it until the transfer; entered and left at a falling edge
    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] smp, input bit typed,
                               input logic signed [SAMPLE_BITS:0] typed_value);
        int                          gap;
        bit                          has_value;
        logic signed [SAMPLE_BITS:0] value;
        gap = send_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_sample = smp;
        do @(posedge aclk); while (!s_ready);
        has_value = decimate_sample(smp, value);
        if (has_value)
            owed_values.push_back(typed ? typed_value : value);
        samples_sent++;
        @(negedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input int style);
        case (style)
            0: draw_sample = SAMPLE_BITS'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: draw_sample = SAMPLE_BITS'(-32768);
                    1: draw_sample = SAMPLE_BITS'(32767);
                    2: draw_sample = SAMPLE_BITS'(-1);
                    3: draw_sample = SAMPLE_BITS'(1);
                    default: draw_sample = '0;
                endcase
            end
            2: draw_sample = SAMPLE_BITS'(int'($urandom_range(0, 200)) - 100);
            default: draw_sample = ($urandom_range(0, 3) != 0) ? SAMPLE_BITS'(-32768)
                                                                : SAMPLE_BITS'(32767);
        endcase
    endfunction

    // result side: random hold-offs, one long stall, and the in-order check
    initial begin
        int hold;
        logic signed [SAMPLE_BITS:0] want;
        hold    = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (owed_values.size() == 0) begin
                    $display("%0t: unexpected value %0d with nothing owed", $time, m_value);
                    mismatch_count++;
                end else begin
                    want = owed_values.pop_front();
                    if (m_value !== want) begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, want, m_value);
                        mismatch_count++;
                    end
                end
                results_checked++;
                // long stall once, while enough short blocks are still to come
                // that the block fills up and stops taking samples
                if (!long_hold_done && results_checked >= LONG_HOLD_AT && phase_eff <= 2
                    && phase_left > 2 * phase_eff + 1) begin
                    hold           = LONG_HOLD;
                    long_hold_done = 1'b1;
                end else begin
                    hold = recv_idle ? $urandom_range(0, 17) : 0;
                end
            end
        end
    end

    // stimulus
    initial begin
        int r;
        int eff;
        int factor;
        int mode;
        int n_items;
        int style;
        int random_sent;

        cfg_we          = 1'b0;
        cfg_index       = CFG_DECIM_FACTOR;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_sample        = '0;
        aresetn         = 1'b0;
        cycle_count     = 0;
        samples_sent    = 0;
        results_checked = 0;
        mismatch_count  = 0;
        phase_count     = 0;
        rms_blocks      = 0;
        mean_blocks     = 0;
        pass_values     = 0;
        random_sent     = 0;
        send_idle       = 1'b1;
        recv_idle       = 1'b1;
        factor_reg      = CFG_DATA_W'(1);
        mode_reg        = 1'b0;
        blk_sum         = 0;
        blk_fill        = 0;
        phase_left      = 0;
        phase_eff       = MAX_FACTOR;
        long_hold_done  = 1'b0;

        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                push_sample(SAMPLE_BITS'(directed_rows[i].smp), directed_rows[i].typed,
                            (SAMPLE_BITS + 1)'(directed_rows[i].want));
            end
        end

        // random phases: new settings, then whole blocks and a partial tail, which may be empty
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                factor = 0;
            else if (r < 62)
                factor = $urandom_range(1, 8);
            else if (r < 85)
                factor = $urandom_range(9, 40);
            else if (r < 95)
                factor = $urandom_range(41, 255);
            else if (r < 98)
                factor = MAX_FACTOR;
            else
                factor = $urandom_range(MAX_FACTOR + 1, FACTOR_MAX);
            mode = $urandom_range(0, 1);
            eff  = (factor > MAX_FACTOR) ? MAX_FACTOR : factor;

            // every phase starts from a drained block
            wait_drained();
            if ($urandom_range(0, 1) != 0) begin
                write_reg(CFG_DECIM_FACTOR, factor);
                write_reg(CFG_ENERGY_MODE, mode);
            end else begin
                write_reg(CFG_ENERGY_MODE, mode);
                write_reg(CFG_DECIM_FACTOR, factor);
            end
            phase_count++;
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);

            if (eff == 0)
                n_items = $urandom_range(8, 40);
            else if (eff <= 40)
                n_items = eff * $urandom_range(1, 4) + $urandom_range(0, eff - 1);
            else
                n_items = eff + $urandom_range(0, 7);
            style = $urandom_range(0, 3);

            phase_eff  = eff;
            phase_left = n_items;
            for (int k = 0; k < n_items; k++) begin
                push_sample(draw_sample(style), 1'b0, '0);
                random_sent++;
                phase_left--;
            end
            phase_left = 0;
        end

        wait_drained();

        $display("covered %0d samples in %0d random phases after the directed table",
                 samples_sent, phase_count);
        $display("checked %0d values: %0d mean blocks, %0d rms blocks, %0d passed through",
                 results_checked, mean_blocks, rms_blocks, pass_values);
        if (mismatch_count == 0) begin
            $display("PASS block_average_decimator_core");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL block_average_decimator_core");
        end
        $finish;
    end

endmodule
